FILE: src/avr_pkg.sv
// shared types and constants of the axis-angle vector rotator
`default_nettype none

package avr_pkg;

  // field widths and fixed-point formats
  localparam int VEC_WIDTH   = 32;
  localparam int ANGLE_WIDTH = 16;
  localparam int AXIS_WIDTH  = 32;
  localparam int FRAC        = 30;
  localparam int SPLIT       = VEC_WIDTH / 2;
  localparam int ENTRY_WIDTH = 36;

  // 2*pi in Q3.30 and 1.0 in Q2.30
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  // horner steps that divide by a constant, done as rounded-up reciprocal products
  localparam int NSTEP = 4;
  typedef logic [30:0] rcp_t;

  localparam rcp_t RCP_SIN [NSTEP] = '{
    31'(((64'd1 << 37) + 64'd71) / 64'd72),
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int SHR_SIN [NSTEP] = '{37, 36, 35, 33};

  localparam rcp_t RCP_COS [NSTEP] = '{
    31'(((64'd1 << 37) + 64'd89) / 64'd90),
    31'(((64'd1 << 36) + 64'd55) / 64'd56),
    31'(((64'd1 << 35) + 64'd29) / 64'd30),
    31'(((64'd1 << 34) + 64'd11) / 64'd12)
  };
  localparam int SHR_COS [NSTEP] = '{37, 36, 35, 34};

  // input transaction
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
    logic signed [AXIS_WIDTH-1:0] axis_x;
    logic signed [AXIS_WIDTH-1:0] axis_y;
    logic signed [AXIS_WIDTH-1:0] axis_z;
    logic [ANGLE_WIDTH-1:0]       angle_turns;
  } in_t;

  // output transaction
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        axis_zero;
  } out_t;

  // item with its sine and cosine, signed Q2.30
  typedef struct packed {
    in_t                item;
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
  } trig_t;

  // item with its rotation matrix, row major
  typedef struct packed {
    in_t                              item;
    logic [8:0][ENTRY_WIDTH-1:0]      m;
  } mat_t;

endpackage

`default_nettype wire

FILE: src/avr_trig.sv
// pipelined sine and cosine of the rotation angle
`default_nettype none

module avr_trig (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  avr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output avr_pkg::trig_t out_data
);

  localparam int AW  = avr_pkg::ANGLE_WIDTH;
  localparam int NST = 2 * avr_pkg::NSTEP + 4;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [AW-3:0] HALF = (AW-2)'(1) << (AW - 3);

  typedef struct packed {
    avr_pkg::in_t item;
    logic [1:0]   quad;
    logic         swap;
    logic [29:0]  x;
    logic [29:0]  x2;
    logic [30:0]  ts;
    logic [30:0]  tc;
    logic [29:0]  ps;
    logic [29:0]  pc;
  } stage_t;

  stage_t st  [NST-1];
  stage_t nxt [NST-1];
  avr_pkg::trig_t out_next;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  // stage advance: a stage loads when empty or when the next one loads
  assign en[NST-1] = !vld[NST-1] || !out_stall;
  for (genvar i = 0; i < NST - 1; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // octant folding and angle to radians
  always_comb begin
    logic [AW-3:0] r;
    logic [AW-3:0] rp;
    logic [AW+30:0] xp;
    r = in_data.angle_turns[AW-3:0];
    nxt[0] = '0;
    nxt[0].item = in_data;
    nxt[0].quad = in_data.angle_turns[AW-1:AW-2];
    nxt[0].swap = r > HALF;
    rp = nxt[0].swap ? (~r + (AW-2)'(1)) : r;
    xp = (AW+31)'(rp) * (AW+31)'(avr_pkg::TWO_PI_Q30);
    nxt[0].x  = xp[AW+29:AW];
    nxt[0].ts = avr_pkg::ONE_Q30;
    nxt[0].tc = avr_pkg::ONE_Q30;
  end

  // angle squared
  always_comb begin
    logic [59:0] sq;
    nxt[1] = st[0];
    sq = 60'(st[0].x) * 60'(st[0].x);
    nxt[1].x2 = sq[59:30];
  end

  // horner steps: product with x2, then reciprocal product
  for (genvar j = 0; j < avr_pkg::NSTEP; j++) begin : g_horner
    always_comb begin
      logic [60:0] prs;
      logic [60:0] prc;
      nxt[2+2*j] = st[1+2*j];
      prs = 61'(st[1+2*j].x2) * 61'(st[1+2*j].ts);
      prc = 61'(st[1+2*j].x2) * 61'(st[1+2*j].tc);
      nxt[2+2*j].ps = prs[59:30];
      nxt[2+2*j].pc = prc[59:30];
    end

    always_comb begin
      logic [60:0] qs;
      logic [60:0] qc;
      nxt[3+2*j] = st[2+2*j];
      qs = 61'(st[2+2*j].ps) * 61'(avr_pkg::RCP_SIN[j]);
      qc = 61'(st[2+2*j].pc) * 61'(avr_pkg::RCP_COS[j]);
      nxt[3+2*j].ts = avr_pkg::ONE_Q30 - 31'(qs >> avr_pkg::SHR_SIN[j]);
      nxt[3+2*j].tc = avr_pkg::ONE_Q30 - 31'(qc >> avr_pkg::SHR_COS[j]);
    end
  end

  // sine product and last cosine product
  always_comb begin
    logic [60:0] prs;
    logic [60:0] prc;
    nxt[NST-2] = st[NST-3];
    prs = 61'(st[NST-3].x) * 61'(st[NST-3].ts);
    prc = 61'(st[NST-3].x2) * 61'(st[NST-3].tc);
    nxt[NST-2].ps = prs[59:30];
    nxt[NST-2].pc = prc[59:30];
  end

  // undo octant fold and apply quadrant signs
  always_comb begin
    logic [30:0] so;
    logic [30:0] co;
    logic signed [31:0] s0;
    logic signed [31:0] c0;
    so = {1'b0, st[NST-2].ps};
    co = avr_pkg::ONE_Q30 - 31'(st[NST-2].pc[29:1]);
    s0 = $signed({1'b0, st[NST-2].swap ? co : so});
    c0 = $signed({1'b0, st[NST-2].swap ? so : co});
    out_next.item = st[NST-2].item;
    unique case (st[NST-2].quad)
      QUAD_0: begin
        out_next.sin_v = s0;
        out_next.cos_v = c0;
      end
      QUAD_1: begin
        out_next.sin_v = c0;
        out_next.cos_v = -s0;
      end
      QUAD_2: begin
        out_next.sin_v = -s0;
        out_next.cos_v = -c0;
      end
      QUAD_3: begin
        out_next.sin_v = -c0;
        out_next.cos_v = s0;
      end
      default: begin
        out_next.sin_v = s0;
        out_next.cos_v = c0;
      end
    endcase
  end

  // stage data registers
  for (genvar i = 0; i < NST - 1; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en[i]) begin
        st[i] <= nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/avr_matrix.sv
// pipelined rotation matrix build from axis, sine and cosine
`default_nettype none

module avr_matrix (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  avr_pkg::trig_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output avr_pkg::mat_t  out_data
);

  localparam int EW = avr_pkg::ENTRY_WIDTH;

  // product order: xx yy zz xy xz yz
  typedef struct packed {
    avr_pkg::in_t       item;
    logic signed [31:0] c;
    logic signed [32:0] w;
    logic [5:0][33:0]   p;
    logic [2:0][33:0]   s;
  } s0_t;

  typedef struct packed {
    avr_pkg::in_t       item;
    logic signed [31:0] c;
    logic [5:0][36:0]   q;
    logic [2:0][33:0]   s;
  } s1_t;

  s0_t r0, r0_next;
  s1_t r1, r1_next;
  avr_pkg::mat_t out_next;

  logic [2:0] vld;
  logic [2:0] en;

  // stage advance
  assign en[2] = !vld[2] || !out_stall;
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];

  assign in_stall  = !en[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  // axis pair products, axis times sine, and one minus cosine
  always_comb begin
    logic signed [63:0] pr [6];
    logic signed [63:0] sp [3];
    pr[0] = in_data.item.axis_x * in_data.item.axis_x;
    pr[1] = in_data.item.axis_y * in_data.item.axis_y;
    pr[2] = in_data.item.axis_z * in_data.item.axis_z;
    pr[3] = in_data.item.axis_x * in_data.item.axis_y;
    pr[4] = in_data.item.axis_x * in_data.item.axis_z;
    pr[5] = in_data.item.axis_y * in_data.item.axis_z;
    sp[0] = in_data.item.axis_x * in_data.sin_v;
    sp[1] = in_data.item.axis_y * in_data.sin_v;
    sp[2] = in_data.item.axis_z * in_data.sin_v;
    r0_next.item = in_data.item;
    r0_next.c    = in_data.cos_v;
    r0_next.w    = 33'sd1073741824 - 33'(in_data.cos_v);
    for (int k = 0; k < 6; k++) begin
      r0_next.p[k] = pr[k][63:30];
    end
    for (int k = 0; k < 3; k++) begin
      r0_next.s[k] = sp[k][63:30];
    end
  end

  // pair products scaled by one minus cosine
  always_comb begin
    logic signed [66:0] qp [6];
    r1_next.item = r0.item;
    r1_next.c    = r0.c;
    r1_next.s    = r0.s;
    for (int k = 0; k < 6; k++) begin
      qp[k] = $signed(r0.p[k]) * r0.w;
      r1_next.q[k] = qp[k][66:30];
    end
  end

  // matrix entries
  always_comb begin
    logic signed [37:0] cc;
    logic signed [37:0] e [9];
    logic signed [37:0] qq [6];
    logic signed [37:0] ss [3];
    cc = 38'(r1.c);
    for (int k = 0; k < 6; k++) begin
      qq[k] = 38'($signed(r1.q[k]));
    end
    for (int k = 0; k < 3; k++) begin
      ss[k] = 38'($signed(r1.s[k]));
    end
    e[0] = cc + qq[0];
    e[1] = qq[3] - ss[2];
    e[2] = qq[4] + ss[1];
    e[3] = qq[3] + ss[2];
    e[4] = cc + qq[1];
    e[5] = qq[5] - ss[0];
    e[6] = qq[4] - ss[1];
    e[7] = qq[5] + ss[0];
    e[8] = cc + qq[2];
    out_next.item = r1.item;
    for (int k = 0; k < 9; k++) begin
      out_next.m[k] = e[k][EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) r0 <= r0_next;
    if (en[1]) r1 <= r1_next;
    if (en[2]) out_data <= out_next;
  end

endmodule

`default_nettype wire

FILE: src/avr_rows.sv
// pipelined matrix times vector with saturation and zero-axis bypass
`default_nettype none

module avr_rows (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  avr_pkg::mat_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output avr_pkg::out_t out_data
);

  localparam int VW   = avr_pkg::VEC_WIDTH;
  localparam int SP   = avr_pkg::SPLIT;
  localparam int EW   = avr_pkg::ENTRY_WIDTH;
  localparam int FR   = avr_pkg::FRAC;
  localparam int HW   = EW + VW - SP;
  localparam int LW   = EW + SP + 1;
  localparam int HSW  = HW + 2;
  localparam int LSW  = LW + 2;
  localparam int TW   = HSW + SP + 1;

  localparam logic [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    avr_pkg::in_t        item;
    logic [8:0][HW-1:0]  hi;
    logic [8:0][LW-1:0]  lo;
  } s0_t;

  typedef struct packed {
    avr_pkg::in_t        item;
    logic [2:0][HSW-1:0] hs;
    logic [2:0][LSW-1:0] ls;
  } s1_t;

  s0_t r0, r0_next;
  s1_t r1, r1_next;
  avr_pkg::out_t out_next;

  logic [2:0] vld;
  logic [2:0] en;

  // stage advance
  assign en[2] = !vld[2] || !out_stall;
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];

  assign in_stall  = !en[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  // partial products on the high and low halves of each component
  always_comb begin
    logic [VW-1:0] v [3];
    logic signed [VW-SP-1:0] vh;
    logic signed [SP:0]      vl;
    logic signed [HW-1:0]    ph;
    logic signed [LW-1:0]    pl;
    v[0] = in_data.item.vec_x;
    v[1] = in_data.item.vec_y;
    v[2] = in_data.item.vec_z;
    r0_next.item = in_data.item;
    for (int k = 0; k < 9; k++) begin
      vh = $signed(v[k % 3][VW-1:SP]);
      vl = $signed({1'b0, v[k % 3][SP-1:0]});
      ph = $signed(in_data.m[k]) * vh;
      pl = $signed(in_data.m[k]) * vl;
      r0_next.hi[k] = ph;
      r0_next.lo[k] = pl;
    end
  end

  // row sums
  always_comb begin
    r1_next.item = r0.item;
    for (int i = 0; i < 3; i++) begin
      r1_next.hs[i] = HSW'($signed(r0.hi[3*i])) + HSW'($signed(r0.hi[3*i+1]))
                    + HSW'($signed(r0.hi[3*i+2]));
      r1_next.ls[i] = LSW'($signed(r0.lo[3*i])) + LSW'($signed(r0.lo[3*i+1]))
                    + LSW'($signed(r0.lo[3*i+2]));
    end
  end

  // recombine, scale, saturate, or pass the vector for a zero axis
  always_comb begin
    logic signed [TW-1:0] t;
    logic [TW-FR-VW:0]    top;
    logic [VW-1:0]        res [3];
    logic                 zero;
    for (int i = 0; i < 3; i++) begin
      t = (TW'($signed(r1.hs[i])) <<< SP) + TW'($signed(r1.ls[i]));
      top = t[TW-1:FR+VW-1];
      if ((&top) || !(|top)) begin
        res[i] = t[FR+VW-1:FR];
      end else begin
        res[i] = t[TW-1] ? MINV : MAXV;
      end
    end
    zero = (r1.item.axis_x == '0) && (r1.item.axis_y == '0) && (r1.item.axis_z == '0);
    out_next.axis_zero = zero;
    out_next.out_x = zero ? r1.item.vec_x : $signed(res[0]);
    out_next.out_y = zero ? r1.item.vec_y : $signed(res[1]);
    out_next.out_z = zero ? r1.item.vec_z : $signed(res[2]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) r0 <= r0_next;
    if (en[1]) r1 <= r1_next;
    if (en[2]) out_data <= out_next;
  end

endmodule

`default_nettype wire

FILE: src/axis_angle_vector_rotate.sv
// top level: axis-angle rotation of a 3d vector, fully pipelined
//
// item channel (item_valid, item_stall, item) carries a Q16.16 vector, a
// Q2.30 unit axis and an angle as a fraction of a turn. result channel
// (result_valid, result_stall, result) returns the rotated vector,
// saturated to Q16.16, with axis_zero set when the axis was all zero (the
// vector then comes back unchanged).
// a transaction moves on a rising edge with valid high and stall low.
// the sine/cosine pipeline (octant fold, square, four horner steps of two
// stages each, final products, quadrant signs) feeds the matrix build,
// which feeds the matrix-vector product.
// one transaction per cycle unless stalled; every stage holds a valid bit
// and loads whenever it is empty or its successor loads, so bubbles close
// up and a new transaction is taken while a result waits.
// synchronous reset empties the pipeline; no result is shown after it.
// when the receiver stalls, the result holds and the stages behind it
// fill up; item_stall rises only once all 18 stages are full.
`default_nettype none

module axis_angle_vector_rotate (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  avr_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output avr_pkg::out_t result
);

  logic           trig_valid;
  logic           trig_stall;
  avr_pkg::trig_t trig_data;
  logic           mat_valid;
  logic           mat_stall;
  avr_pkg::mat_t  mat_data;

  // sine and cosine
  avr_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_stall  (item_stall),
    .in_data   (item),
    .out_valid (trig_valid),
    .out_stall (trig_stall),
    .out_data  (trig_data)
  );

  // rotation matrix
  avr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .in_stall  (trig_stall),
    .in_data   (trig_data),
    .out_valid (mat_valid),
    .out_stall (mat_stall),
    .out_data  (mat_data)
  );

  // matrix times vector
  avr_rows u_rows (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat_valid),
    .in_stall  (mat_stall),
    .in_data   (mat_data),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (result)
  );

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // an empty trig output stage means the input is never held off
  a_trig_open: assert property (@(posedge clk) disable iff (rst)
    !trig_valid |-> !item_stall)
    else $error("input stalled while sine/cosine pipeline not full");

  // an empty result stage never holds off the matrix stage
  a_rows_open: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !mat_stall)
    else $error("matrix stage stalled while result stage empty");

endmodule

`default_nettype wire
